FILE: hdl/phs_pkg.sv
// shared constants and item types for the packed header size screener
package phs_pkg;

  localparam int MAX_SEGMENTS = 4096;
  // segment count held as 1..MAX_SEGMENTS
  localparam int SEG_W = $clog2(MAX_SEGMENTS + 1);
  // unpacked word position, at least 9 bits so a run count always fits
  localparam int WPOS_W = ($clog2(MAX_SEGMENTS + 1) > 8) ? $clog2(MAX_SEGMENTS + 1) : 9;
  localparam int TOTAL_W = 48;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 64;
  localparam logic [PADDR_W-1:0] ADDR_MAX_BODY = '0;
  localparam logic [TOTAL_W-1:0] MAX_BODY_RESET = 48'd67108864;

  localparam logic [7:0] TAG_ZERO = 8'h00;
  localparam logic [7:0] TAG_FULL = 8'hFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic               header_found;
    logic [TOTAL_W-1:0] total_bytes;
    logic               too_many_segments;
    logic               over_cap;
  } out_item_t;

  typedef struct packed {
    logic               found;
    logic               absurd;
    logic [TOTAL_W-1:0] total;
  } msg_result_t;

endpackage

FILE: hdl/phs_decoder.sv
// per-byte unpacking of the packed stream and header size bookkeeping
module phs_decoder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  phs_pkg::in_item_t    item,
  output logic                 done,
  output phs_pkg::msg_result_t res
);

  localparam logic [2:0] PH_TAG    = 3'd0;
  localparam logic [2:0] PH_LIT    = 3'd1;
  localparam logic [2:0] PH_ZCOUNT = 3'd2;
  localparam logic [2:0] PH_FLIT   = 3'd3;
  localparam logic [2:0] PH_FCOUNT = 3'd4;
  localparam logic [2:0] PH_FRUN   = 3'd5;
  localparam logic [2:0] PH_HALT   = 3'd6;

  localparam int SEG_W   = phs_pkg::SEG_W;
  localparam int WPOS_W  = phs_pkg::WPOS_W;
  localparam int TOTAL_W = phs_pkg::TOTAL_W;

  function automatic logic [2:0] ctz8(input logic [7:0] x);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (x[i]) r = 3'(i);
    end
    return r;
  endfunction

  // whole words needed to hold the count word and all size words
  function automatic logic [WPOS_W-1:0] need_words(input logic [SEG_W-1:0] cnt);
    logic [SEG_W+2:0] bytes4;
    bytes4 = {1'b0, cnt, 2'b00} + (SEG_W+3)'(11);
    return WPOS_W'(bytes4 >> 3);
  endfunction

  logic [2:0]         phase, phase_next;
  logic [7:0]         tag_bits, tag_bits_next;
  logic [2:0]         bw, bw_next;
  logic [7:0]         run_left, run_left_next;
  logic [WPOS_W-1:0]  wpos, wpos_next;
  logic [SEG_W-1:0]   seg_cnt, seg_cnt_next;
  logic               seg_over, seg_over_next;
  logic [63:0]        wa, wa_next;
  logic [TOTAL_W-1:0] sum, sum_next;
  logic               decided, decided_next;

  logic [63:0]        wa_put;
  logic [7:0]         higher;
  logic               more;
  logic [WPOS_W-1:0]  room;
  logic [7:0]         clip;
  logic               commit;
  logic [63:0]        cword;
  logic [7:0]         adv;
  logic               ge;
  logic [31:0]        lo, hi;
  logic [WPOS_W:0]    twice_w, cnt_ext;
  logic               add_lo, add_hi;

  always_comb begin
    wa_put = wa;
    wa_put[{bw, 3'b000} +: 8] = item.data_byte;
  end

  // tag bits above the lane just written
  assign higher = tag_bits & ~((8'd2 << bw) - 8'd1);
  assign more   = (higher != 8'd0);
  assign room   = WPOS_W'(phs_pkg::MAX_SEGMENTS) - wpos;
  assign clip   = ({{(WPOS_W-8){1'b0}}, item.data_byte} < room) ? item.data_byte : room[7:0];

  always_comb begin
    phase_next    = phase;
    tag_bits_next = tag_bits;
    bw_next       = bw;
    run_left_next = run_left;
    wa_next       = wa;
    commit        = 1'b0;
    cword         = '0;
    adv           = 8'd0;
    ge            = 1'b0;

    case (phase)
      PH_TAG: begin
        if (item.data_byte == phs_pkg::TAG_ZERO) begin
          commit     = 1'b1;
          adv        = 8'd1;
          phase_next = PH_ZCOUNT;
        end else if (item.data_byte == phs_pkg::TAG_FULL) begin
          bw_next    = 3'd0;
          wa_next    = '0;
          phase_next = PH_FLIT;
        end else begin
          tag_bits_next = item.data_byte;
          bw_next       = ctz8(item.data_byte);
          wa_next       = '0;
          phase_next    = PH_LIT;
          // cut off right after the tag: the word is all zero
          if (item.last_byte) begin
            commit = 1'b1;
            adv    = 8'd1;
            ge     = 1'b1;
          end
        end
      end
      PH_LIT: begin
        wa_next = wa_put;
        if (!more || item.last_byte) begin
          commit = 1'b1;
          cword  = wa_put;
          adv    = 8'd1;
          ge     = 1'b1;
        end else begin
          bw_next = ctz8(higher);
        end
      end
      PH_ZCOUNT: begin
        adv = clip;
        ge  = 1'b1;
      end
      PH_FLIT: begin
        wa_next = wa_put;
        bw_next = bw + 3'd1;
        if (bw == 3'd7) begin
          commit     = 1'b1;
          cword      = wa_put;
          adv        = 8'd1;
          phase_next = PH_FCOUNT;
        end
      end
      PH_FCOUNT: begin
        if (clip == 8'd0) begin
          ge = 1'b1;
        end else if (item.last_byte) begin
          adv = clip;
          ge  = 1'b1;
        end else begin
          run_left_next = clip;
          bw_next       = 3'd0;
          wa_next       = '0;
          phase_next    = PH_FRUN;
        end
      end
      PH_FRUN: begin
        wa_next = wa_put;
        bw_next = bw + 3'd1;
        if (item.last_byte) begin
          // current word padded with zeros, the rest of the run as zero words
          commit = 1'b1;
          cword  = wa_put;
          adv    = run_left;
          ge     = 1'b1;
        end else if (bw == 3'd7) begin
          commit        = 1'b1;
          cword         = wa_put;
          adv           = 8'd1;
          wa_next       = '0;
          run_left_next = run_left - 8'd1;
          if (run_left == 8'd1) ge = 1'b1;
        end
      end
      default: begin
      end
    endcase

    lo = cword[31:0];
    hi = cword[63:32];

    seg_cnt_next  = seg_cnt;
    seg_over_next = seg_over;
    if (commit && wpos == '0) begin
      seg_over_next = (lo >= 32'(phs_pkg::MAX_SEGMENTS));
      seg_cnt_next  = lo[SEG_W-1:0] + SEG_W'(1);
    end

    // half-word h of word w is size entry h-1
    twice_w = {wpos, 1'b0};
    cnt_ext = (WPOS_W+1)'(seg_cnt_next);
    add_lo  = commit && (wpos != '0) && !seg_over_next && (twice_w <= cnt_ext);
    add_hi  = commit && !seg_over_next && (twice_w < cnt_ext);

    sum_next = sum + (add_lo ? TOTAL_W'({lo, 3'b000}) : '0)
                   + (add_hi ? TOTAL_W'({hi, 3'b000}) : '0);
    wpos_next = wpos + WPOS_W'(adv);

    decided_next = decided;
    if (ge) begin
      decided_next = seg_over_next || (wpos_next >= need_words(seg_cnt_next));
      phase_next   = (decided_next || wpos_next >= WPOS_W'(phs_pkg::MAX_SEGMENTS)) ?
                     PH_HALT : PH_TAG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && item.last_byte)) begin
      phase    <= PH_TAG;
      tag_bits <= '0;
      bw       <= '0;
      run_left <= '0;
      wpos     <= '0;
      seg_cnt  <= '0;
      seg_over <= 1'b0;
      wa       <= '0;
      sum      <= '0;
      decided  <= 1'b0;
    end else if (take) begin
      phase    <= phase_next;
      tag_bits <= tag_bits_next;
      bw       <= bw_next;
      run_left <= run_left_next;
      wpos     <= wpos_next;
      seg_cnt  <= seg_cnt_next;
      seg_over <= seg_over_next;
      wa       <= wa_next;
      sum      <= sum_next;
      decided  <= decided_next;
    end
  end

  assign done       = take && item.last_byte;
  assign res.found  = decided_next;
  assign res.absurd = decided_next && seg_over_next;
  assign res.total  = decided_next ? (seg_over_next ? '1 : sum_next) : '0;

endmodule

FILE: hdl/packed_header_size_screener.sv
// top level of the packed header size screener: config port and result stages
//
// The item channel takes one byte of a zero-packed message per cycle, with
// last_byte set on the final byte. The result channel gives one item per
// message: header_found, total_bytes, too_many_segments and over_cap.
// Both channels use valid/stall; an item moves when valid is high and stall
// is low. max_body_bytes sits at byte address 0 of the 64-bit config port.
// Throughput is one byte per cycle while item_stall is low, set by the
// per-byte state update (a three-input 48-bit add of the decoded segment
// sizes). The result is registered twice, in the mid stage and then in
// the output register, which it enters when that register is free.
// A finished result can wait in the stage behind the output register, so
// item_stall rises only when both hold a result and result_stall is high.
// Reset clears the message state and both result stages and sets
// max_body_bytes to 67108864.
module packed_header_size_screener (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [phs_pkg::PADDR_W-1:0]   paddr,
  input  logic [phs_pkg::PDATA_W-1:0]   pwdata,
  output logic [phs_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  phs_pkg::in_item_t             item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output phs_pkg::out_item_t            result
);

  logic [phs_pkg::TOTAL_W-1:0] max_body_bytes;
  logic                        take;
  logic                        done;
  phs_pkg::msg_result_t        res;
  logic                        mid_valid;
  phs_pkg::msg_result_t        mid;
  logic                        out_free;
  logic                        mid_move;
  logic                        over_cap;

  assign pready = 1'b1;
  assign prdata = (paddr == phs_pkg::ADDR_MAX_BODY) ? phs_pkg::PDATA_W'(max_body_bytes) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_bytes <= phs_pkg::MAX_BODY_RESET;
    end else if (psel && penable && pwrite && paddr == phs_pkg::ADDR_MAX_BODY) begin
      max_body_bytes <= pwdata[phs_pkg::TOTAL_W-1:0];
    end
  end

  assign out_free   = !result_valid || !result_stall;
  assign mid_move   = mid_valid && out_free;
  assign item_stall = mid_valid && !mid_move;
  assign take       = item_valid && !item_stall;

  phs_decoder u_decoder (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (item),
    .done (done),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (done) begin
      mid_valid <= 1'b1;
    end else if (mid_move) begin
      mid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) mid <= res;
  end

  assign over_cap = mid.found && (mid.absurd || mid.total > max_body_bytes);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (mid_move) begin
      result_valid <= 1'b1;
    end else if (out_free) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_move) begin
      result.header_found      <= mid.found;
      result.total_bytes       <= mid.total;
      result.too_many_segments <= mid.absurd;
      result.over_cap          <= over_cap;
    end
  end

`ifndef ASSERT_OFF
  a_cap_needs_header: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.over_cap |-> result.header_found)
    else $error("over_cap without a header");

  a_absurd_saturates: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.too_many_segments |->
      result.header_found && result.over_cap && result.total_bytes == '1)
    else $error("absurd segment count not saturated");

  a_no_header_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.header_found |->
      result.total_bytes == '0 && !result.too_many_segments)
    else $error("total given without a header");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    mid_valid && result_valid && result_stall |-> item_stall)
    else $error("item taken with both result stages full");
`endif

endmodule
